>>> src/elt_pkg.sv
// Shared types and constants for the escaped line tokenizer.
// No dependencies; imported by elt_parser, escaped_line_tokenizer_core, elt_checker and the testbench top.
package elt_pkg;

  // Width and ceiling of the argument index field
  localparam int unsigned ARG_IDX_W   = 6;
  localparam int unsigned ARG_IDX_MAX = (1 << ARG_IDX_W) - 1;

  // Line parser modes
  typedef enum logic [1:0] {
    MODE_START,
    MODE_TOKEN,
    MODE_POST,
    MODE_SKIP
  } mode_e;

  // Message type codes
  localparam logic [1:0] MSG_REQUEST = 2'd0;
  localparam logic [1:0] MSG_REPLY   = 2'd1;
  localparam logic [1:0] MSG_INFORM  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  // One result beat
  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 has_byte;
    logic                 arg_end;
    logic                 line_end;
    logic [ARG_IDX_W-1:0] arg_index;
    logic [1:0]           msg_type;
    logic                 bad_line;
    logic                 arg_overflow;
  } result_t;

  // Byte that follows a backslash; the empty-argument mark is handled by the caller
  function automatic logic [7:0] decode_escape(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_LOW_E: v = CH_ESC;
      CH_LOW_N: v = CH_LF;
      CH_LOW_R: v = CH_CR;
      CH_LOW_T: v = CH_TAB;
      CH_ZERO:  v = CH_NUL;
      CH_UNDER: v = CH_SPACE;
      default:  v = c;
    endcase
    return v;
  endfunction

endpackage

>>> src/elt_parser.sv
// Per-byte line parser: holds the line state and forms at most one result per byte.
// Depends on elt_pkg.
module elt_parser #(
  parameter int unsigned MAX_ARGS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output logic             res_valid_o,
  output elt_pkg::result_t res_o
);
  import elt_pkg::*;

  localparam int unsigned ArgCapInt = (MAX_ARGS - 1 > ARG_IDX_MAX) ? ARG_IDX_MAX : MAX_ARGS - 1;
  localparam logic [ARG_IDX_W-1:0] ArgCap = ARG_IDX_W'(ArgCapInt);

  mode_e                mode_q, mode_d;
  logic                 esc_q, esc_d;
  logic [ARG_IDX_W-1:0] arg_q, arg_d;
  logic [1:0]           type_q, type_d;
  logic                 ovf_q, ovf_d;

  logic       eol, blank, marker;
  logic       emit, has, aend, lend, bad;
  logic [7:0] val;

  assign eol    = (byte_i == CH_LF) || (byte_i == CH_CR);
  assign blank  = (byte_i == CH_SPACE) || (byte_i == CH_TAB);
  assign marker = (byte_i == CH_QMARK) || (byte_i == CH_BANG) || (byte_i == CH_HASH);

  // Next line state and result for the byte in hand
  always_comb begin
    mode_d = mode_q;
    esc_d  = esc_q;
    arg_d  = arg_q;
    type_d = type_q;
    ovf_d  = ovf_q;
    emit   = 1'b0;
    has    = 1'b0;
    aend   = 1'b0;
    lend   = 1'b0;
    bad    = 1'b0;
    val    = byte_i;
    case (mode_q)
      MODE_TOKEN: begin
        if (eol) begin
          // escaped or not, CR/LF closes argument and line
          esc_d  = 1'b0;
          mode_d = MODE_START;
          emit   = 1'b1;
          aend   = 1'b1;
          lend   = 1'b1;
        end else if (esc_q) begin
          esc_d = 1'b0;
          if (byte_i != CH_AT) begin
            emit = 1'b1;
            has  = 1'b1;
            val  = decode_escape(byte_i);
          end
        end else if (blank) begin
          mode_d = MODE_POST;
          emit   = 1'b1;
          aend   = 1'b1;
        end else if (byte_i == CH_BSLASH) begin
          esc_d = 1'b1;
        end else begin
          emit = 1'b1;
          has  = 1'b1;
        end
      end
      MODE_POST: begin
        if (eol) begin
          mode_d = MODE_START;
          emit   = 1'b1;
          lend   = 1'b1;
        end else if (!blank) begin
          // new argument: index saturates at the cap
          if (arg_q < ArgCap) begin
            arg_d = arg_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          mode_d = MODE_TOKEN;
          if (byte_i == CH_BSLASH) begin
            esc_d = 1'b1;
          end else begin
            emit = 1'b1;
            has  = 1'b1;
          end
        end
      end
      MODE_SKIP: begin
        if (eol) begin
          mode_d = MODE_START;
        end
      end
      MODE_START: begin
        esc_d = 1'b0;
        if (!(blank || eol)) begin
          if (marker) begin
            type_d = (byte_i == CH_QMARK) ? MSG_REQUEST :
                     (byte_i == CH_BANG)  ? MSG_REPLY : MSG_INFORM;
            arg_d  = '0;
            ovf_d  = 1'b0;
            mode_d = MODE_TOKEN;
            emit   = 1'b1;
            has    = 1'b1;
          end else begin
            mode_d = MODE_SKIP;
            emit   = 1'b1;
            bad    = 1'b1;
          end
        end
      end
      default: begin
        mode_d = MODE_START;
      end
    endcase
  end

  // Result fields reflect the updated line state; a bad-line beat is all zero but the flag
  always_comb begin
    res_o = '0;
    if (bad) begin
      res_o.bad_line = 1'b1;
    end else begin
      res_o.out_byte     = has ? val : 8'h00;
      res_o.has_byte     = has;
      res_o.arg_end      = aend;
      res_o.line_end     = lend;
      res_o.arg_index    = arg_d;
      res_o.msg_type     = type_d;
      res_o.arg_overflow = ovf_d;
    end
  end

  assign res_valid_o = emit;

  // Line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
      esc_q  <= 1'b0;
      arg_q  <= '0;
      type_q <= MSG_REQUEST;
      ovf_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      esc_q  <= esc_d;
      arg_q  <= arg_d;
      type_q <= type_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

>>> src/escaped_line_tokenizer_core.sv
// Escaped line tokenizer top level: input byte register, parser, result register.
// An accepted input beat passes through the input byte register and the parser to the result register.
// Throughput: one byte per cycle; the input register drains whenever the result
// register is empty or being taken, so in_ready_o drops only while a result stalls.
// Reset (rst_ni, async, active low) empties both registers and returns to line start.
// Depends on elt_pkg and elt_parser.
module escaped_line_tokenizer_core #(
  parameter int unsigned MAX_ARGS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          has_byte_o,
  output logic                          arg_end_o,
  output logic                          line_end_o,
  output logic [elt_pkg::ARG_IDX_W-1:0] arg_index_o,
  output logic [1:0]                    msg_type_o,
  output logic                          bad_line_o,
  output logic                          arg_overflow_o
);
  import elt_pkg::*;

  localparam int unsigned ArgCapInt = (MAX_ARGS - 1 > ARG_IDX_MAX) ? ARG_IDX_MAX : MAX_ARGS - 1;
  localparam logic [ARG_IDX_W-1:0] ArgCap = ARG_IDX_W'(ArgCapInt);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  // Parse the held byte when the result register can take its result
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  elt_parser #(
    .MAX_ARGS(MAX_ARGS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (in_byte_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_q.out_byte;
  assign has_byte_o     = out_q.has_byte;
  assign arg_end_o      = out_q.arg_end;
  assign line_end_o     = out_q.line_end;
  assign arg_index_o    = out_q.arg_index;
  assign msg_type_o     = out_q.msg_type;
  assign bad_line_o     = out_q.bad_line;
  assign arg_overflow_o = out_q.arg_overflow;

  // A bad-line beat carries nothing else
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_line_o |-> !has_byte_o && !arg_end_o && !line_end_o &&
      (arg_index_o == '0) && (msg_type_o == MSG_REQUEST) && !arg_overflow_o)
    else $error("bad-line beat carries other fields");

  // Argument index never passes its cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (arg_index_o <= ArgCap))
    else $error("argument index above cap");

  // Input stalls only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Message type is never the unused code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (msg_type_o <= MSG_INFORM))
    else $error("unused message type code");

endmodule

>>> tb/elt_checker.sv
// Checker for the escaped line tokenizer: watches both channels, predicts each result beat
// from the accepted input bytes and compares field by field. Depends on elt_pkg.
module elt_checker #(
  parameter int unsigned MAX_ARGS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [7:0]                    in_byte_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [7:0]                    out_byte_i,
  input  logic                          has_byte_i,
  input  logic                          arg_end_i,
  input  logic                          line_end_i,
  input  logic [elt_pkg::ARG_IDX_W-1:0] arg_index_i,
  input  logic [1:0]                    msg_type_i,
  input  logic                          bad_line_i,
  input  logic                          arg_overflow_i,
  output int unsigned                   err_cnt_o,
  output int unsigned                   pending_o
);
  import elt_pkg::*;

  // Highest argument index before saturation
  localparam int unsigned IDX_CAP = (MAX_ARGS - 1 > ARG_IDX_MAX) ? ARG_IDX_MAX : MAX_ARGS - 1;

  // Shadow parser state
  mode_e                mode_q;
  logic                 esc_q;
  logic [ARG_IDX_W-1:0] arg_idx_q;
  logic [1:0]           line_kind_q;
  logic                 ovf_q;

  result_t     tokens_expected_q[$];
  int unsigned beat_cnt;

  initial err_cnt_o = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt_o < 100) begin
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", beat_cnt, what, got, want);
    end
    err_cnt_o++;
  endtask

  // Byte stood for by a backslash pair
  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      CH_LOW_E: return CH_ESC;
      CH_LOW_N: return CH_LF;
      CH_LOW_R: return CH_CR;
      CH_LOW_T: return CH_TAB;
      CH_ZERO:  return CH_NUL;
      CH_UNDER: return CH_SPACE;
      default:  return c;
    endcase
  endfunction

  // Result beat tagged with the current line state
  function automatic result_t token_beat(input logic [7:0] b, input logic has,
                                         input logic aend, input logic lend);
    result_t r;
    r.out_byte     = has ? b : 8'h00;
    r.has_byte     = has;
    r.arg_end      = aend;
    r.line_end     = lend;
    r.arg_index    = arg_idx_q;
    r.msg_type     = line_kind_q;
    r.bad_line     = 1'b0;
    r.arg_overflow = ovf_q;
    return r;
  endfunction

  // Advance the shadow parser by one byte, queueing the beat it causes
  task automatic tokenize(input logic [7:0] c);
    logic    eol;
    logic    blank;
    result_t bad;
    eol   = (c == CH_LF) || (c == CH_CR);
    blank = (c == CH_SPACE) || (c == CH_TAB);
    case (mode_q)
      MODE_TOKEN: begin
        if (eol) begin
          esc_q  = 1'b0;
          mode_q = MODE_START;
          tokens_expected_q.push_back(token_beat(8'h00, 1'b0, 1'b1, 1'b1));
        end else if (esc_q) begin
          esc_q = 1'b0;
          // escaped @ marks an empty argument and yields nothing
          if (c != CH_AT) tokens_expected_q.push_back(token_beat(unescape(c), 1'b1, 1'b0, 1'b0));
        end else if (blank) begin
          mode_q = MODE_POST;
          tokens_expected_q.push_back(token_beat(8'h00, 1'b0, 1'b1, 1'b0));
        end else if (c == CH_BSLASH) begin
          esc_q = 1'b1;
        end else begin
          tokens_expected_q.push_back(token_beat(c, 1'b1, 1'b0, 1'b0));
        end
      end
      MODE_POST: begin
        if (eol) begin
          mode_q = MODE_START;
          tokens_expected_q.push_back(token_beat(8'h00, 1'b0, 1'b0, 1'b1));
        end else if (!blank) begin
          if (arg_idx_q < IDX_CAP) arg_idx_q++;
          else ovf_q = 1'b1;
          mode_q = MODE_TOKEN;
          if (c == CH_BSLASH) esc_q = 1'b1;
          else tokens_expected_q.push_back(token_beat(c, 1'b1, 1'b0, 1'b0));
        end
      end
      MODE_SKIP: begin
        if (eol) mode_q = MODE_START;
      end
      default: begin
        esc_q = 1'b0;
        if (blank || eol) begin
          mode_q = MODE_START;
        end else if (c == CH_QMARK || c == CH_BANG || c == CH_HASH) begin
          line_kind_q = (c == CH_QMARK) ? MSG_REQUEST : (c == CH_BANG) ? MSG_REPLY : MSG_INFORM;
          arg_idx_q   = '0;
          ovf_q       = 1'b0;
          mode_q      = MODE_TOKEN;
          tokens_expected_q.push_back(token_beat(c, 1'b1, 1'b0, 1'b0));
        end else begin
          mode_q       = MODE_SKIP;
          bad          = '0;
          bad.bad_line = 1'b1;
          tokens_expected_q.push_back(bad);
        end
      end
    endcase
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      mode_q      = MODE_START;
      esc_q       = 1'b0;
      arg_idx_q   = '0;
      line_kind_q = MSG_REQUEST;
      ovf_q       = 1'b0;
      beat_cnt    = 0;
      tokens_expected_q.delete();
      pending_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) tokenize(in_byte_i);
      if (out_valid_i && out_ready_i) begin
        got = {out_byte_i, has_byte_i, arg_end_i, line_end_i, arg_index_i, msg_type_i,
               bad_line_i, arg_overflow_i};
        if (tokens_expected_q.size() == 0) begin
          report_mismatch("arrived with nothing expected, out_byte", got.out_byte, 0);
        end else begin
          want = tokens_expected_q.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", got.out_byte, want.out_byte);
          if (got.has_byte !== want.has_byte)
            report_mismatch("has_byte", got.has_byte, want.has_byte);
          if (got.arg_end !== want.arg_end)
            report_mismatch("arg_end", got.arg_end, want.arg_end);
          if (got.line_end !== want.line_end)
            report_mismatch("line_end", got.line_end, want.line_end);
          if (got.arg_index !== want.arg_index)
            report_mismatch("arg_index", got.arg_index, want.arg_index);
          if (got.msg_type !== want.msg_type)
            report_mismatch("msg_type", got.msg_type, want.msg_type);
          if (got.bad_line !== want.bad_line)
            report_mismatch("bad_line", got.bad_line, want.bad_line);
          if (got.arg_overflow !== want.arg_overflow)
            report_mismatch("arg_overflow", got.arg_overflow, want.arg_overflow);
        end
        beat_cnt++;
      end
      pending_o = tokens_expected_q.size();
    end
  end

endmodule

>>> tb/tb_escaped_line_tokenizer_core.sv
// Testbench top for escaped_line_tokenizer_core: clock, reset, byte stream and output stalls.
// Checking is done by elt_checker; depends on elt_pkg and the block under test.
module tb_escaped_line_tokenizer_core;
  import elt_pkg::*;

  localparam int unsigned MAX_ARGS   = 64;
  localparam int unsigned RAND_ITEMS = 950;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           in_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [7:0]           out_byte;
  logic                 has_byte;
  logic                 arg_end;
  logic                 line_end;
  logic [ARG_IDX_W-1:0] arg_index;
  logic [1:0]           msg_type;
  logic                 bad_line;
  logic                 arg_overflow;
  int unsigned          err_cnt;
  int unsigned          pending;

  logic [7:0]  line_q[$];
  bit          no_gaps;
  int unsigned items_sent;
  int unsigned hold_cnt;

  escaped_line_tokenizer_core #(
    .MAX_ARGS(MAX_ARGS)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .in_byte_i     (in_byte),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_o    (out_byte),
    .has_byte_o    (has_byte),
    .arg_end_o     (arg_end),
    .line_end_o    (line_end),
    .arg_index_o   (arg_index),
    .msg_type_o    (msg_type),
    .bad_line_o    (bad_line),
    .arg_overflow_o(arg_overflow)
  );

  elt_checker #(
    .MAX_ARGS(MAX_ARGS)
  ) u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_byte_i     (in_byte),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_byte_i    (out_byte),
    .has_byte_i    (has_byte),
    .arg_end_i     (arg_end),
    .line_end_i    (line_end),
    .arg_index_i   (arg_index),
    .msg_type_i    (msg_type),
    .bad_line_i    (bad_line),
    .arg_overflow_i(arg_overflow),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Output stalls: random runs of ready and stall, mostly short
  initial out_ready = 1'b0;
  always @(negedge clk) begin
    int unsigned r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt = 0;
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_ready <= 1'b1;
        hold_cnt = $urandom_range(0, 6);
      end else if (r < 85) begin
        out_ready <= 1'b0;
        hold_cnt = $urandom_range(0, 2);
      end else if (r < 93) begin
        out_ready <= 1'b0;
        hold_cnt = $urandom_range(8, 40);
      end else begin
        out_ready <= 1'b1;
        hold_cnt = $urandom_range(30, 80);
      end
    end
  end

  // Idle cycles between input beats
  task automatic idle_gap();
    int unsigned r;
    int unsigned n;
    if (no_gaps) return;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offer one byte from a falling edge and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    idle_gap();
  endtask

  task automatic send_line();
    while (line_q.size() != 0) send_byte(line_q.pop_front());
  endtask

  // Any byte that stays inside an argument
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_BSLASH)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] escape_target();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 6))
      0:       return CH_LOW_E;
      1:       return CH_LOW_N;
      2:       return CH_LOW_R;
      3:       return CH_LOW_T;
      4:       return CH_ZERO;
      5:       return CH_UNDER;
      default: return CH_AT;
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] eol_char();
    return ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
  endfunction

  // Argument text, with escape pairs mixed in
  task automatic push_arg_text(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        line_q.push_back(CH_BSLASH);
        line_q.push_back(escape_target());
      end else begin
        line_q.push_back(plain_char());
      end
    end
  endtask

  // Well-formed message line; long ones come near or run past the argument limit
  task automatic build_message(input bit long_line);
    int unsigned nargs;
    repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0) line_q.push_back(blank_char());
    case ($urandom_range(0, 2))
      0:       line_q.push_back(CH_QMARK);
      1:       line_q.push_back(CH_BANG);
      default: line_q.push_back(CH_HASH);
    endcase
    push_arg_text(long_line ? 0 : $urandom_range(0, 4));
    nargs = long_line ? $urandom_range(62, 70) : $urandom_range(0, 5);
    for (int unsigned a = 0; a < nargs; a++) begin
      repeat ($urandom_range(1, 2)) line_q.push_back(blank_char());
      push_arg_text(long_line ? $urandom_range(1, 2) : $urandom_range(1, 4));
    end
    if ($urandom_range(0, 5) == 0) line_q.push_back(blank_char());
    if ($urandom_range(0, 9) == 0) line_q.push_back(CH_BSLASH);
    line_q.push_back(eol_char());
  endtask

  // Line with a bad start byte and some junk before its end
  task automatic build_bad_line();
    logic [7:0] c;
    c = plain_char();
    while (c == CH_QMARK || c == CH_BANG || c == CH_HASH) c = plain_char();
    line_q.push_back(c);
    repeat ($urandom_range(0, 8)) line_q.push_back(plain_char());
    line_q.push_back(eol_char());
  endtask

  // Stimulus
  initial begin
    int unsigned line_no;
    int unsigned r;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_byte  = 8'h00;
    no_gaps  = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: blanks at line start, escapes, empty argument, escaped end of line,
    // line end between arguments, bad start byte, extreme byte values
    line_q = '{CH_SPACE, CH_CR, CH_QMARK, CH_BSLASH, CH_LOW_E, CH_BSLASH, CH_AT, CH_TAB,
               CH_BSLASH, CH_AT, CH_SPACE, CH_BSLASH, CH_LF,
               CH_BANG, 8'hFF, CH_SPACE, CH_LF,
               CH_NUL, 8'hFF, CH_CR,
               CH_HASH, CH_BSLASH, CH_UNDER, CH_BSLASH, CH_CR};
    send_line();

    // Random lines: mostly well-formed, some bad lines, some raw noise
    items_sent = 0;
    line_no    = 0;
    while (items_sent < RAND_ITEMS) begin
      no_gaps = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 75)
        build_message((line_no % 40 == 3) || ($urandom_range(0, 59) == 0));
      else if (r < 90)
        build_bad_line();
      else
        repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      items_sent += line_q.size();
      send_line();
      line_no++;
    end
    in_valid <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
src/elt_pkg.sv
src/elt_parser.sv
src/escaped_line_tokenizer_core.sv
tb/elt_checker.sv
tb/tb_escaped_line_tokenizer_core.sv
